// ----- hw/rtl/ndro_pkg.sv -----
`default_nettype none

package ndro_pkg;

    // Ring geometry and buffer size.
    localparam int TX_SLOTS     = 8;
    localparam int RX_SLOTS     = 32;
    localparam int BUFFER_BYTES = 2048;

    localparam int TX_IW      = (TX_SLOTS > 1) ? $clog2(TX_SLOTS) : 1;
    localparam int RX_IW      = (RX_SLOTS > 1) ? $clog2(RX_SLOTS) : 1;
    localparam int STORE_LW   = $clog2(BUFFER_BYTES + 1);

    // Fixed field widths of the request and result items.
    localparam int ACTION_W = 2;
    localparam int FLEN_W   = 16;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 12;
    localparam int SLOT_W   = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_HOST_SEND = 2'd0,
        ACT_HOST_RECV = 2'd1,
        ACT_DEV_TXDONE = 2'd2,
        ACT_DEV_ARRIVE = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_RING     = 3'd1,
        ST_NOT_UP   = 3'd2,
        ST_TOO_LONG = 3'd3,
        ST_DROPPED  = 3'd4
    } t_status;

    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_EXEC = 1'b1
    } t_ctl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the incoming request
        logic execute;   // apply the latched request and load the result
    } t_ctl_cmd;

endpackage

`default_nettype wire

// ----- hw/rtl/ndro_ctrl.sv -----
`default_nettype none

module ndro_ctrl
    import ndro_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_ctl_cmd      o_cmd
);

    t_ctl_state r_state;
    t_ctl_state n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;

    // The result register can take a new result when it is empty or being drained.
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            CTL_IDLE: begin
                if (i_in_valid) begin
                    n_state = CTL_EXEC;
                end
            end
            CTL_EXEC: begin
                if (w_out_free) begin
                    n_state = CTL_IDLE;
                end
            end
            default: n_state = CTL_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall    = 1'b1;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            CTL_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            CTL_EXEC: begin
                o_cmd.execute = w_out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.execute) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CTL_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // A result is produced only out of the execute state.
    a_exec_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |-> (r_state == CTL_EXEC))
        else $error("execute issued outside the execute state");

    // Every executed request shows up as a valid result in the next cycle.
    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |=> r_out_valid)
        else $error("executed request did not produce a result");

    // A request is never captured while a previous one is still pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == CTL_EXEC) && !o_cmd.capture)
        else $error("request captured while another is pending");

    // A waiting result is never overwritten while the consumer stalls.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_cmd.execute)
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

// ----- hw/rtl/ndro_datapath.sv -----
`default_nettype none

module ndro_datapath
    import ndro_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_data,
    input  wire t_ctl_cmd            i_cmd,
    input  wire logic [ACTION_W-1:0] i_action,
    input  wire logic [FLEN_W-1:0]   i_frame_length,
    input  wire logic [FLEN_W-1:0]   i_caller_max,
    output logic [STATUS_W-1:0]      o_status,
    output logic [LEN_W-1:0]         o_result_length,
    output logic [SLOT_W-1:0]        o_slot_index,
    output logic [SLOT_W-1:0]        o_tail_write,
    output logic                     o_tail_valid
);

    // Configuration and ring control state.
    logic                  r_driver_up;
    logic [TX_SLOTS-1:0]   r_tx_done;
    logic [RX_SLOTS-1:0]   r_rx_done;
    logic [TX_IW-1:0]      r_tx_host;
    logic [RX_IW-1:0]      r_rx_host;
    logic [TX_IW-1:0]      r_tx_head;
    logic [RX_IW-1:0]      r_rx_head;
    logic [RX_IW-1:0]      r_rx_tail;

    // Length stores; entries are written before any legal read.
    logic [STORE_LW-1:0]   r_tx_len [TX_SLOTS];
    logic [STORE_LW-1:0]   r_rx_len [RX_SLOTS];

    // Latched request.
    t_action               r_act;
    logic [FLEN_W-1:0]     r_flen;
    logic [FLEN_W-1:0]     r_cmax;

    // Store read data taken with the request. The pointers and the stores only
    // change on execute, so the values stay current until the request runs.
    logic [STORE_LW-1:0]   r_tx_rd_len;
    logic [STORE_LW-1:0]   r_rx_rd_len;

    // Result register.
    logic [STATUS_W-1:0]   r_res_status;
    logic [LEN_W-1:0]      r_len;
    logic [SLOT_W-1:0]     r_slot;
    logic [SLOT_W-1:0]     r_tail;
    logic                  r_tail_ok;

    // Decision for the latched request.
    t_status               n_status;
    logic [LEN_W-1:0]      n_len;
    logic [SLOT_W-1:0]     n_slot;
    logic [SLOT_W-1:0]     n_tail;
    logic                  n_tail_ok;
    logic                  w_send_ok;
    logic                  w_recv_ok;
    logic                  w_txdone_ok;
    logic                  w_arrive_ok;

    logic [TX_IW-1:0]      w_tx_host_inc;
    logic [RX_IW-1:0]      w_rx_host_inc;
    logic [TX_IW-1:0]      w_tx_head_inc;
    logic [RX_IW-1:0]      w_rx_head_inc;
    logic                  w_too_long;
    logic [STORE_LW-1:0]   w_sat_len;
    logic [FLEN_W-1:0]     w_rx_clip;

    assign w_tx_host_inc = (r_tx_host == TX_IW'(TX_SLOTS - 1)) ? '0 : r_tx_host + 1'b1;
    assign w_rx_host_inc = (r_rx_host == RX_IW'(RX_SLOTS - 1)) ? '0 : r_rx_host + 1'b1;
    assign w_tx_head_inc = (r_tx_head == TX_IW'(TX_SLOTS - 1)) ? '0 : r_tx_head + 1'b1;
    assign w_rx_head_inc = (r_rx_head == RX_IW'(RX_SLOTS - 1)) ? '0 : r_rx_head + 1'b1;

    assign w_too_long  = r_flen > FLEN_W'(BUFFER_BYTES);
    assign w_sat_len   = w_too_long ? STORE_LW'(BUFFER_BYTES) : STORE_LW'(r_flen);
    assign w_rx_clip   = (FLEN_W'(r_rx_rd_len) > r_cmax) ? r_cmax : FLEN_W'(r_rx_rd_len);

    always_comb begin
        n_status    = ST_OK;
        n_len       = '0;
        n_slot      = '0;
        n_tail      = '0;
        n_tail_ok   = 1'b0;
        w_send_ok   = 1'b0;
        w_recv_ok   = 1'b0;
        w_txdone_ok = 1'b0;
        w_arrive_ok = 1'b0;
        case (r_act)
            ACT_HOST_SEND: begin
                n_slot = SLOT_W'(r_tx_host);
                if (!r_driver_up) begin
                    n_status = ST_NOT_UP;
                end else if (w_too_long) begin
                    n_status = ST_TOO_LONG;
                end else if (!r_tx_done[r_tx_host]) begin
                    n_status = ST_RING;
                end else begin
                    w_send_ok = 1'b1;
                    n_len     = LEN_W'(r_flen);
                    n_tail    = SLOT_W'(w_tx_host_inc);
                    n_tail_ok = 1'b1;
                end
            end
            ACT_HOST_RECV: begin
                n_slot = SLOT_W'(r_rx_host);
                if (!r_driver_up) begin
                    n_status = ST_NOT_UP;
                end else if (!r_rx_done[r_rx_host]) begin
                    n_status = ST_RING;
                end else begin
                    w_recv_ok = 1'b1;
                    n_len     = LEN_W'(w_rx_clip);
                    n_tail    = SLOT_W'(r_rx_host);
                    n_tail_ok = 1'b1;
                end
            end
            ACT_DEV_TXDONE: begin
                n_slot = SLOT_W'(r_tx_head);
                if (r_tx_done[r_tx_head]) begin
                    n_status = ST_RING;
                end else begin
                    w_txdone_ok = 1'b1;
                    n_len       = LEN_W'(r_tx_rd_len);
                end
            end
            ACT_DEV_ARRIVE: begin
                n_slot = SLOT_W'(r_rx_head);
                if (r_rx_head == r_rx_tail) begin
                    n_status = ST_DROPPED;
                end else begin
                    w_arrive_ok = 1'b1;
                    n_len       = LEN_W'(w_sat_len);
                end
            end
            default: n_status = ST_RING;
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_driver_up <= 1'b0;
            r_tx_done   <= '1;
            r_rx_done   <= '0;
            r_tx_host   <= '0;
            r_rx_host   <= '0;
            r_tx_head   <= '0;
            r_rx_head   <= '0;
            r_rx_tail   <= RX_IW'(RX_SLOTS - 1);
        end else begin
            if (i_cfg_we) begin
                r_driver_up <= i_cfg_data;
            end
            if (i_cmd.execute) begin
                if (w_send_ok) begin
                    r_tx_done[r_tx_host] <= 1'b0;
                    r_tx_host            <= w_tx_host_inc;
                end
                if (w_recv_ok) begin
                    r_rx_done[r_rx_host] <= 1'b0;
                    r_rx_tail            <= r_rx_host;
                    r_rx_host            <= w_rx_host_inc;
                end
                if (w_txdone_ok) begin
                    r_tx_done[r_tx_head] <= 1'b1;
                    r_tx_head            <= w_tx_head_inc;
                end
                if (w_arrive_ok) begin
                    r_rx_done[r_rx_head] <= 1'b1;
                    r_rx_head            <= w_rx_head_inc;
                end
            end
        end
    end

    // Payload registers and length stores.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act       <= t_action'(i_action);
            r_flen      <= i_frame_length;
            r_cmax      <= i_caller_max;
            r_tx_rd_len <= r_tx_len[r_tx_head];
            r_rx_rd_len <= r_rx_len[r_rx_host];
        end
        if (i_cmd.execute) begin
            r_res_status <= n_status;
            r_len        <= n_len;
            r_slot       <= n_slot;
            r_tail       <= n_tail;
            r_tail_ok    <= n_tail_ok;
            if (w_send_ok) begin
                r_tx_len[r_tx_host] <= STORE_LW'(r_flen);
            end
            if (w_arrive_ok) begin
                r_rx_len[r_rx_head] <= w_sat_len;
            end
        end
    end

    assign o_status        = r_res_status;
    assign o_result_length = r_len;
    assign o_slot_index    = r_slot;
    assign o_tail_write    = r_tail;
    assign o_tail_valid    = r_tail_ok;

    // Only one ring update kind can fire per executed request.
    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute |-> $onehot0({w_send_ok, w_recv_ok, w_txdone_ok, w_arrive_ok}))
        else $error("more than one ring update for one request");

    // A tail write is only reported together with success status.
    a_tail_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute |=> (!r_tail_ok || (r_res_status == ST_OK)))
        else $error("tail write reported on a failed request");

    // A failed request always reports zero length.
    a_fail_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute |=> ((r_res_status == ST_OK) || (r_len == '0)))
        else $error("nonzero length on a failed request");

endmodule

`default_nettype wire

// ----- hw/rtl/nic_descriptor_ring_ownership_top.sv -----
`default_nettype none
// A request is latched in the capture step; its result is registered in the execute step.
// A new request is taken only once the previous one has executed, and execute waits on a stalled output.
// A finished result waits in the output register while the next request is already taken.
// Reset is synchronous and active low; it marks all transmit slots done, all receive slots empty,
// clears every ring pointer, sets the receive tail to the last slot and takes the driver down.

module nic_descriptor_ring_ownership_top
    import ndro_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Configuration: the driver-up register.
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_data,
    // Request channel.
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [ACTION_W-1:0] i_action,
    input  wire logic [FLEN_W-1:0]   i_frame_length,
    input  wire logic [FLEN_W-1:0]   i_caller_max,
    // Result channel.
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic [LEN_W-1:0]         o_result_length,
    output logic [SLOT_W-1:0]        o_slot_index,
    output logic [SLOT_W-1:0]        o_tail_write,
    output logic                     o_tail_valid
);

    // The controller sequences each request through a capture step and an execute step.
    // Execute waits only while the previous result is still held by a stalled consumer.
    t_ctl_cmd w_cmd;

    ndro_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the done bits, the length stores, the four ring pointers and the receive tail.
    // It evaluates the host send, host receive, transmit completion and arrival checks
    // combinationally and loads the result register on execute.
    ndro_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (w_cmd),
        .i_action        (i_action),
        .i_frame_length  (i_frame_length),
        .i_caller_max    (i_caller_max),
        .o_status        (o_status),
        .o_result_length (o_result_length),
        .o_slot_index    (o_slot_index),
        .o_tail_write    (o_tail_write),
        .o_tail_valid    (o_tail_valid)
    );

endmodule

`default_nettype wire
